// ----- src/alpha_over_blend_core_assert.svh -----
// assertion macros shared by the checker files of the blend core
// depends on signals clk and rst being visible where a macro is used
`ifndef ALPHA_OVER_BLEND_CORE_ASSERT_SVH
`define ALPHA_OVER_BLEND_CORE_ASSERT_SVH

// property checked outside reset
`define AOB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define AOB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/aob_pkg.sv -----
// shared types, constants and the divide-by-255 helper of the blend core
// no dependencies
`timescale 1ns / 1ps

package aob_pkg;

  localparam int CH_W           = 8;
  localparam int NCH            = 3;   // blue, green, red
  localparam int NUM_W          = 17;  // blended color numerator
  localparam int QW             = 9;   // quotient bits, top bit only flags saturation
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = (QW + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int ARITH_STAGES   = 4;
  localparam int PIPE_STAGES    = ARITH_STAGES + DIV_STAGES;

  localparam logic [CH_W-1:0] ALPHA_MAX = 8'd255;

  // pixel taken as is when the source is fully transparent or opaque
  typedef struct packed {
    logic            byp;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] alpha;
  } pass_t;

  // floor(x / 255), exact for x up to 65279
  function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = 17'(x) + 17'(x[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

endpackage

// ----- src/aob_div.sv -----
// pipelined restoring divider, numerator by 8-bit blended alpha
// depends on aob_pkg
`timescale 1ns / 1ps

module aob_div (
  input  logic                           clk,
  input  logic [aob_pkg::DIV_STAGES-1:0] en,
  input  logic [aob_pkg::NUM_W-1:0]      num,
  input  logic [aob_pkg::CH_W-1:0]       den,
  output logic [aob_pkg::QW-1:0]         quo
);
  import aob_pkg::*;

  logic [NUM_W-1:0] rem_q [DIV_STAGES-1];
  logic [CH_W-1:0]  den_q [DIV_STAGES-1];
  logic [QW-1:0]    quo_q [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stg
    logic [NUM_W-1:0] r_in;
    logic [NUM_W-1:0] r_out;
    logic [QW-1:0]    q_in;
    logic [QW-1:0]    q_out;
    logic [CH_W-1:0]  d_in;

    if (j == 0) begin : g_first
      assign r_in = num;
      assign q_in = '0;
      assign d_in = den;
    end else begin : g_next
      assign r_in = rem_q[j-1];
      assign q_in = quo_q[j-1];
      assign d_in = den_q[j-1];
    end

    // two quotient bits per stage, one in the last, msb first
    always_comb begin
      r_out = r_in;
      q_out = q_in;
      for (int k = QW - 1 - j * BITS_PER_STAGE;
           k > QW - 1 - (j + 1) * BITS_PER_STAGE && k >= 0; k--) begin
        if (r_out >= (NUM_W'(d_in) << k)) begin
          r_out    = r_out - (NUM_W'(d_in) << k);
          q_out[k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        quo_q[j] <= q_out;
      end
    end

    if (j < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem_q[j] <= r_out;
          den_q[j] <= d_in;
        end
      end
    end
  end

  assign quo = quo_q[DIV_STAGES-1];

endmodule

// ----- src/alpha_over_blend_core.sv -----
// over-operator blend of one non-premultiplied 8-bit bgra pixel pair
// depends on aob_pkg and aob_div
`timescale 1ns / 1ps

// Blends a source pixel over a destination pixel, both 8-bit BGRA and not
// premultiplied. A source alpha of 0 returns the destination unchanged, a
// source alpha of 255 returns the source colors with alpha 255. Otherwise
// out_alpha = sa + floor(da*(255-sa)/255) and each color is
// floor((cs*sa + floor(cd*da*(255-sa)/255)) / out_alpha), saturated at 255.
// Throughput is one pixel pair per clock unless the output stalls. An input
// transfer reaches out_valid through four arithmetic stages (alpha product,
// divide by 255 and blended alpha, destination products, numerator sum) and
// five color divider stages, two quotient bits each and one in the last.
// Each stage holds its own valid bit and advances whenever the stage after
// it can take its contents, so a stall on the output only backs up as far
// as needed and bubbles are squeezed out.

module alpha_over_blend_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] src_blue,
  input  logic [7:0] src_green,
  input  logic [7:0] src_red,
  input  logic [7:0] src_alpha,
  input  logic [7:0] dst_blue,
  input  logic [7:0] dst_green,
  input  logic [7:0] dst_red,
  input  logic [7:0] dst_alpha,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_blue,
  output logic [7:0] out_green,
  output logic [7:0] out_red,
  output logic [7:0] out_alpha
);
  import aob_pkg::*;

  // per-stage valid bits and advance enables
  logic [PIPE_STAGES-1:0] v;
  logic [PIPE_STAGES-1:0] en;

  // input channels, index 0 blue, 1 green, 2 red
  logic [CH_W-1:0] cs_in [NCH];
  logic [CH_W-1:0] cd_in [NCH];

  // stage 0: alpha product and source color products
  logic [15:0]     s0_p;
  logic [CH_W-1:0] s0_sa;
  logic [15:0]     s0_csa [NCH];
  logic [CH_W-1:0] s0_cd  [NCH];
  pass_t           s0_pass;
  pass_t           pass_in;

  // stage 1: p split into 255*a + b, blended alpha
  logic [CH_W-1:0] s1_a;
  logic [CH_W-1:0] s1_b;
  logic [CH_W-1:0] s1_na;
  logic [15:0]     s1_csa [NCH];
  logic [CH_W-1:0] s1_cd  [NCH];
  pass_t           s1_pass;
  logic [CH_W-1:0] a_next;

  // stage 2: destination products against both parts of p
  logic [15:0]     s2_cda [NCH];
  logic [15:0]     s2_cdb [NCH];
  logic [15:0]     s2_csa [NCH];
  logic [CH_W-1:0] s2_na;
  pass_t           s2_pass;

  // stage 3: color numerators
  logic [NUM_W-1:0] s3_num [NCH];
  logic [CH_W-1:0]  s3_na;
  pass_t            s3_pass;

  // side band that rides along the divider stages
  logic [CH_W-1:0] dv_na   [DIV_STAGES];
  pass_t           dv_pass [DIV_STAGES];
  logic [QW-1:0]   quo     [NCH];
  logic [CH_W-1:0] color   [NCH];

  assign cs_in[0] = src_blue;
  assign cs_in[1] = src_green;
  assign cs_in[2] = src_red;
  assign cd_in[0] = dst_blue;
  assign cd_in[1] = dst_green;
  assign cd_in[2] = dst_red;

  // a stage advances when it is empty or the next one advances
  always_comb begin
    en[PIPE_STAGES-1] = !v[PIPE_STAGES-1] || out_ready;
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // transparent keeps destination, opaque takes source with full alpha
  always_comb begin
    pass_in.byp = (src_alpha == '0) || (src_alpha == ALPHA_MAX);
    if (src_alpha == ALPHA_MAX) begin
      pass_in.blue  = src_blue;
      pass_in.green = src_green;
      pass_in.red   = src_red;
      pass_in.alpha = ALPHA_MAX;
    end else begin
      pass_in.blue  = dst_blue;
      pass_in.green = dst_green;
      pass_in.red   = dst_red;
      pass_in.alpha = dst_alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_p    <= 16'(dst_alpha) * 16'(ALPHA_MAX - src_alpha);
      s0_sa   <= src_alpha;
      s0_pass <= pass_in;
      for (int c = 0; c < NCH; c++) begin
        s0_csa[c] <= 16'(cs_in[c]) * 16'(src_alpha);
        s0_cd[c]  <= cd_in[c];
      end
    end
  end

  // p = 255*a + b, so floor(cd*p/255) = cd*a + floor(cd*b/255)
  assign a_next = div255(s0_p);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_a    <= a_next;
      s1_b    <= 8'(s0_p - {a_next, 8'd0} + 16'(a_next));
      s1_na   <= s0_sa + a_next;
      s1_pass <= s0_pass;
      for (int c = 0; c < NCH; c++) begin
        s1_csa[c] <= s0_csa[c];
        s1_cd[c]  <= s0_cd[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_na   <= s1_na;
      s2_pass <= s1_pass;
      for (int c = 0; c < NCH; c++) begin
        s2_cda[c] <= 16'(s1_cd[c]) * 16'(s1_a);
        s2_cdb[c] <= 16'(s1_cd[c]) * 16'(s1_b);
        s2_csa[c] <= s1_csa[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_na   <= s2_na;
      s3_pass <= s2_pass;
      for (int c = 0; c < NCH; c++) begin
        s3_num[c] <= NUM_W'(s2_csa[c]) + NUM_W'(s2_cda[c]) + NUM_W'(div255(s2_cdb[c]));
      end
    end
  end

  // one divider per color channel, sharing the stage enables
  for (genvar c = 0; c < NCH; c++) begin : g_div
    aob_div u_div (
      .clk (clk),
      .en  (en[PIPE_STAGES-1:ARITH_STAGES]),
      .num (s3_num[c]),
      .den (s3_na),
      .quo (quo[c])
    );
    // quotient can reach 256 for small alpha, clamp it
    assign color[c] = quo[c][QW-1] ? ALPHA_MAX : quo[c][CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (en[ARITH_STAGES+j]) begin
        if (j == 0) begin
          dv_na[j]   <= s3_na;
          dv_pass[j] <= s3_pass;
        end else begin
          dv_na[j]   <= dv_na[j-1];
          dv_pass[j] <= dv_pass[j-1];
        end
      end
    end
  end

  // output select from the last stage registers
  always_comb begin
    if (dv_pass[DIV_STAGES-1].byp) begin
      out_blue  = dv_pass[DIV_STAGES-1].blue;
      out_green = dv_pass[DIV_STAGES-1].green;
      out_red   = dv_pass[DIV_STAGES-1].red;
      out_alpha = dv_pass[DIV_STAGES-1].alpha;
    end else begin
      out_blue  = color[0];
      out_green = color[1];
      out_red   = color[2];
      out_alpha = dv_na[DIV_STAGES-1];
    end
  end

endmodule

// ----- src/aob_checker.sv -----
// port-level checks of the blend core, bound to its top level
// depends on alpha_over_blend_core_assert.svh
`timescale 1ns / 1ps
`include "alpha_over_blend_core_assert.svh"

module aob_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_blue,
  input logic [7:0] out_green,
  input logic [7:0] out_red,
  input logic [7:0] out_alpha
);

  // a stalled result transfer keeps valid and payload
  `AOB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_blue) && $stable(out_green) && $stable(out_red) && $stable(out_alpha), "output changed while stalled")

  // back pressure on the input only comes from a waiting result
  `AOB_ASSERT(a_ready_cause, !in_ready |-> out_valid, "input stalled with no result pending")

  // reset empties the pipeline
  `AOB_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result valid right after reset")

  // with an empty output side nothing can block an input transfer
  `AOB_ASSERT(a_accept_free, in_valid && !out_valid |-> in_ready, "input refused while output empty")

endmodule

bind alpha_over_blend_core aob_checker u_aob_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_blue  (out_blue),
  .out_green (out_green),
  .out_red   (out_red),
  .out_alpha (out_alpha)
);

// ----- bench/tb_alpha_over_blend_core.sv -----
// self-checking bench for alpha_over_blend_core: over-operator blend of bgra pixel pairs
// depends on aob_pkg (channel width, pipeline depth) and the alpha_over_blend_core rtl
`timescale 1ns / 1ps

module tb_alpha_over_blend_core;

  typedef logic [aob_pkg::CH_W-1:0] chan_t;

  // one input transfer: source and destination pixel
  typedef struct packed {
    chan_t sb, sg, sr, sa;
    chan_t db, dg, dr, da;
  } pixel_pair_t;

  // one output transfer: blended pixel
  typedef struct packed {
    chan_t blue, green, red, alpha;
  } blend_px_t;

  // receiver back-pressure styles
  typedef enum int {RX_FREE, RX_COIN, RX_QUARTER, RX_LONG} rx_mode_t;

  localparam chan_t OPAQUE      = 8'd255;
  localparam chan_t CLEAR       = 8'd0;
  localparam int    DRAIN_WAIT  = 4 * aob_pkg::PIPE_STAGES;
  localparam int    N_RANDOM    = 450;
  localparam int    MAX_REPORTS = 10;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  chan_t src_blue, src_green, src_red, src_alpha;
  chan_t dst_blue, dst_green, dst_red, dst_alpha;
  logic  out_valid;
  logic  out_ready;
  chan_t out_blue, out_green, out_red, out_alpha;

  alpha_over_blend_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .src_blue  (src_blue),
    .src_green (src_green),
    .src_red   (src_red),
    .src_alpha (src_alpha),
    .dst_blue  (dst_blue),
    .dst_green (dst_green),
    .dst_red   (dst_red),
    .dst_alpha (dst_alpha),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red),
    .out_alpha (out_alpha)
  );

  // pixel pairs still to be sent, blended pixels still to come back
  pixel_pair_t pending_px[$];
  blend_px_t   blend_expect[$];

  int n_total;
  int accepted_cnt;
  int checked_cnt;
  int mismatch_cnt;
  int unexpected_cnt;
  int n_clear_src;
  int n_opaque_src;
  int n_partial_src;

  // ---------------------------------------------------------------------------
  // blend prediction
  // ---------------------------------------------------------------------------

  // one color channel of the partial case, quotient clamped at full scale
  function automatic chan_t mix_channel(input int unsigned cs, input int unsigned cd,
                                        input int unsigned sa, input int unsigned da,
                                        input int unsigned oa);
    int unsigned num;
    int unsigned q;
    num = cs * sa + (cd * da * (255 - sa)) / 255;
    q   = num / oa;
    return (q > 255) ? OPAQUE : chan_t'(q);
  endfunction

  function automatic blend_px_t blend_over(input pixel_pair_t p);
    blend_px_t   r;
    int unsigned sa;
    int unsigned da;
    int unsigned oa;
    sa = 32'(p.sa);
    da = 32'(p.da);
    // transparent source (and the guarded zero-alpha case) keep the destination
    r = '{blue: p.db, green: p.dg, red: p.dr, alpha: p.da};
    if (p.sa == OPAQUE) begin
      r = '{blue: p.sb, green: p.sg, red: p.sr, alpha: OPAQUE};
    end else if (p.sa != CLEAR) begin
      oa = sa + (da * (255 - sa)) / 255;
      if (oa != 0) begin
        r.blue  = mix_channel(32'(p.sb), 32'(p.db), sa, da, oa);
        r.green = mix_channel(32'(p.sg), 32'(p.dg), sa, da, oa);
        r.red   = mix_channel(32'(p.sr), 32'(p.dr), sa, da, oa);
        r.alpha = (oa > 255) ? OPAQUE : chan_t'(oa);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_pair(input chan_t sb, input chan_t sg, input chan_t sr, input chan_t sa,
                          input chan_t db, input chan_t dg, input chan_t dr, input chan_t da);
    pending_px.push_back('{sb: sb, sg: sg, sr: sr, sa: sa, db: db, dg: dg, dr: dr, da: da});
  endtask

  // colors lean on the rails, where saturation and pass-through show up
  function automatic chan_t pick_color();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return CLEAR;
    if (sel == 1) return OPAQUE;
    return chan_t'($urandom_range(0, 255));
  endfunction

  // alphas lean on the bypass values and on the edges of the partial range
  function automatic chan_t pick_alpha();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return CLEAR;
      1:       return OPAQUE;
      2:       return chan_t'($urandom_range(1, 3));
      3:       return chan_t'($urandom_range(252, 254));
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // clock, reset, stimulus and end of run
  // ---------------------------------------------------------------------------

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    out_ready      = 1'b0;
    src_blue       = '0;
    src_green      = '0;
    src_red        = '0;
    src_alpha      = '0;
    dst_blue       = '0;
    dst_green      = '0;
    dst_red        = '0;
    dst_alpha      = '0;
    accepted_cnt   = 0;
    checked_cnt    = 0;
    mismatch_cnt   = 0;
    unexpected_cnt = 0;
    n_clear_src    = 0;
    n_opaque_src   = 0;
    n_partial_src  = 0;

    // directed: transparent source passes the destination through
    add_pair(8'h12, 8'h34, 8'h56, CLEAR,  8'h9a, 8'hbc, 8'hde, 8'h78);
    add_pair(8'hff, 8'hff, 8'hff, CLEAR,  8'hff, 8'hff, 8'hff, OPAQUE);
    add_pair(8'h00, 8'h00, 8'h00, CLEAR,  8'h00, 8'h00, 8'h00, CLEAR);
    // opaque source replaces colors, alpha forced to full
    add_pair(8'ha5, 8'h5a, 8'hff, OPAQUE, 8'h3c, 8'hc3, 8'h00, 8'h11);
    add_pair(8'h00, 8'h00, 8'h00, OPAQUE, 8'hff, 8'hff, 8'hff, CLEAR);
    add_pair(8'hff, 8'hff, 8'hff, OPAQUE, 8'hff, 8'hff, 8'hff, OPAQUE);
    // faint source alpha: truncation pushes the quotient past 255 over faint destinations; last case over a strong one
    add_pair(8'hff, 8'hff, 8'hff, 8'd1,   8'hff, 8'hff, 8'hff, 8'd1);
    add_pair(8'hff, 8'hff, 8'hff, 8'd3,   8'hff, 8'hff, 8'hff, 8'd3);
    add_pair(8'hff, 8'hfe, 8'hfd, 8'd2,   8'hff, 8'hff, 8'hff, 8'd200);
    // edges of the partial range
    add_pair(8'h80, 8'h40, 8'h20, 8'd1,   8'h10, 8'h08, 8'h04, CLEAR);
    add_pair(8'h00, 8'h00, 8'h00, 8'd1,   8'hff, 8'hff, 8'hff, OPAQUE);
    add_pair(8'hff, 8'h00, 8'h7f, 8'd254, 8'h00, 8'hff, 8'h80, OPAQUE);
    add_pair(8'h01, 8'h02, 8'h03, 8'd254, 8'hfd, 8'hfe, 8'hff, CLEAR);
    // mostly mid-range mixes
    add_pair(8'h80, 8'h80, 8'h80, 8'd128, 8'h40, 8'hc0, 8'h00, 8'd128);
    add_pair(8'hff, 8'h00, 8'haa, 8'd128, 8'h00, 8'hff, 8'h55, CLEAR);
    add_pair(8'h00, 8'h00, 8'h00, 8'd2,   8'hff, 8'hff, 8'hff, OPAQUE);
    add_pair(8'hff, 8'hff, 8'hff, 8'd127, 8'h00, 8'h00, 8'h00, 8'd200);
    add_pair(8'haa, 8'h55, 8'haa, 8'd85,  8'h55, 8'haa, 8'h55, 8'd170);

    // random pixel pairs
    for (int i = 0; i < N_RANDOM; i++) begin
      add_pair(pick_color(), pick_color(), pick_color(), pick_alpha(),
               pick_color(), pick_color(), pick_color(), pick_alpha());
    end
    n_total = pending_px.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // every pair sent, every blended pixel back, then a quiet tail
    while (accepted_cnt < n_total) @(posedge clk);
    while (blend_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d pixel pairs (%0d transparent, %0d opaque, %0d partial source alpha)",
             accepted_cnt, n_clear_src, n_opaque_src, n_partial_src);
    $display("checked %0d blended pixels: %0d mismatches, %0d unexpected",
             checked_cnt, mismatch_cnt, unexpected_cnt);
    if (mismatch_cnt == 0 && unexpected_cnt == 0 && blend_expect.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("timeout with %0d of %0d pairs sent, %0d results outstanding",
             accepted_cnt, n_total, blend_expect.size());
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: bursts of transfers separated by random idle gaps
  // ---------------------------------------------------------------------------

  int          burst_left;
  int          gap_left;
  logic        drv_valid;
  pixel_pair_t drv_px;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      // transfer completed at this edge: record what the block owes us
      if (in_valid && in_ready) begin
        drv_px = pending_px.pop_front();
        blend_expect.push_back(blend_over(drv_px));
        accepted_cnt++;
        if (drv_px.sa == CLEAR) begin
          n_clear_src++;
        end else if (drv_px.sa == OPAQUE) begin
          n_opaque_src++;
        end else begin
          n_partial_src++;
        end
      end
      // a new item only once the held one is gone, valid set exactly once
      if (!in_valid || in_ready) begin
        drv_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_px.size() != 0) begin
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
          end
          drv_px    = pending_px[0];
          drv_valid = 1'b1;
          src_blue  <= drv_px.sb;
          src_green <= drv_px.sg;
          src_red   <= drv_px.sr;
          src_alpha <= drv_px.sa;
          dst_blue  <= drv_px.db;
          dst_green <= drv_px.dg;
          dst_red   <= drv_px.dr;
          dst_alpha <= drv_px.da;
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
        in_valid <= drv_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver back-pressure: style changes at random, each held for a randomly drawn count of cycles
  // ---------------------------------------------------------------------------

  rx_mode_t    stall_mode;
  int          mode_left;
  logic [31:0] rx_tick;
  logic        rx_ready;

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_mode = RX_FREE;
      mode_left  = 40;
      rx_tick    = '0;
    end else begin
      rx_tick++;
      if (mode_left == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(30, 150);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        RX_FREE:    rx_ready = 1'b1;
        RX_COIN:    rx_ready = 1'($urandom_range(0, 1));
        RX_QUARTER: rx_ready = (rx_tick[1:0] == 2'b00);
        default:    rx_ready = (rx_tick[4:0] < 5'd6);   // long stalls, short windows
      endcase
      out_ready <= rx_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: each output transfer against the oldest expected pixel
  // ---------------------------------------------------------------------------

  blend_px_t want_px;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (blend_expect.size() == 0) begin
        unexpected_cnt++;
        if (mismatch_cnt + unexpected_cnt <= MAX_REPORTS) begin
          $display("unexpected output transfer: b=%02h g=%02h r=%02h a=%02h",
                   out_blue, out_green, out_red, out_alpha);
        end
      end else begin
        want_px = blend_expect.pop_front();
        checked_cnt++;
        if (out_blue  !== want_px.blue  || out_green !== want_px.green ||
            out_red   !== want_px.red   || out_alpha !== want_px.alpha) begin
          mismatch_cnt++;
          if (mismatch_cnt + unexpected_cnt <= MAX_REPORTS) begin
            $display("pixel %0d bgra: want %02h %02h %02h %02h, got %02h %02h %02h %02h",
                     checked_cnt - 1, want_px.blue, want_px.green, want_px.red,
                     want_px.alpha, out_blue, out_green, out_red, out_alpha);
          end
        end
      end
    end
  end

endmodule
